@@ rtl/wpp_pkg.sv @@
package wpp_pkg;

  localparam int unsigned HEADER_BYTES = 44;
  localparam int unsigned POS_W        = 6;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_STOP    = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_RIFF      = 4'd1,
    ERR_WAVE      = 4'd2,
    ERR_FMT       = 4'd3,
    ERR_NOT_PCM   = 4'd4,
    ERR_CHANNELS  = 4'd5,
    ERR_RATE      = 4'd6,
    ERR_BITS      = 4'd7,
    ERR_DATA_TAG  = 4'd8,
    ERR_EARLY_END = 4'd9
  } err_t;

  typedef enum logic {
    CFG_SAMPLE_RATE = 1'b0,
    CFG_BIT_DEPTH   = 1'b1
  } cfg_idx_t;

  localparam logic [POS_W-1:0] POS_FORMAT   = POS_W'(21);
  localparam logic [POS_W-1:0] POS_CHANNELS = POS_W'(23);
  localparam logic [POS_W-1:0] POS_RATE     = POS_W'(27);
  localparam logic [POS_W-1:0] POS_BITS     = POS_W'(35);
  localparam logic [POS_W-1:0] POS_LENGTH   = POS_W'(43);
  localparam logic [POS_W-1:0] POS_DONE     = POS_W'(HEADER_BYTES);

  localparam logic [15:0] PCM_FORMAT   = 16'd1;
  localparam logic [15:0] ONE_CHANNEL  = 16'd1;
  localparam logic [31:0] RESET_RATE   = 32'd48000;
  localparam logic [15:0] RESET_DEPTH  = 16'd16;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
    err_t       err;
  } tag_t;

  typedef struct packed {
    logic [POS_W-1:0] byte_position;
    logic [31:0]      field_shift;
    logic [31:0]      bytes_remaining;
    logic [31:0]      stored_length;
    phase_t           parse_phase;
    err_t             error_latched;
  } state_t;

  typedef struct packed {
    logic [31:0] rate_req;
    logic [15:0] depth_req;
  } cfg_t;

  typedef struct packed {
    logic        sample_valid;
    logic [7:0]  sample_byte;
    logic        last_sample;
    logic        header_done;
    err_t        error_code;
    logic [31:0] data_length;
  } result_t;

  function automatic tag_t tag_expect(input logic [POS_W-1:0] pos);
    tag_t t;
    t.hit = 1'b1;
    t.ch  = 8'h00;
    t.err = ERR_NONE;
    unique case (pos)
      6'd0:    begin t.ch = "R"; t.err = ERR_RIFF;     end
      6'd1:    begin t.ch = "I"; t.err = ERR_RIFF;     end
      6'd2:    begin t.ch = "F"; t.err = ERR_RIFF;     end
      6'd3:    begin t.ch = "F"; t.err = ERR_RIFF;     end
      6'd8:    begin t.ch = "W"; t.err = ERR_WAVE;     end
      6'd9:    begin t.ch = "A"; t.err = ERR_WAVE;     end
      6'd10:   begin t.ch = "V"; t.err = ERR_WAVE;     end
      6'd11:   begin t.ch = "E"; t.err = ERR_WAVE;     end
      6'd12:   begin t.ch = "f"; t.err = ERR_FMT;      end
      6'd13:   begin t.ch = "m"; t.err = ERR_FMT;      end
      6'd14:   begin t.ch = "t"; t.err = ERR_FMT;      end
      6'd15:   begin t.ch = " "; t.err = ERR_FMT;      end
      6'd36:   begin t.ch = "d"; t.err = ERR_DATA_TAG; end
      6'd37:   begin t.ch = "a"; t.err = ERR_DATA_TAG; end
      6'd38:   begin t.ch = "t"; t.err = ERR_DATA_TAG; end
      6'd39:   begin t.ch = "a"; t.err = ERR_DATA_TAG; end
      default: t.hit = 1'b0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/wpp_step.sv @@
module wpp_step (
  input  wpp_pkg::state_t  state_cur,
  input  wpp_pkg::cfg_t    cfg,
  input  logic [7:0]       byte_in,
  input  logic             first_byte,
  input  logic             end_of_file,
  output wpp_pkg::state_t  state_next,
  output wpp_pkg::result_t result
);
  import wpp_pkg::*;

  state_t      s0;
  tag_t        tag;
  logic [31:0] shifted;
  logic [31:0] remaining_dec;
  err_t        hdr_err;
  err_t        err;

  assign tag           = tag_expect(s0.byte_position);
  assign shifted       = {byte_in, s0.field_shift[31:8]};
  assign remaining_dec = s0.bytes_remaining - 32'd1;

  always_comb begin
    s0 = state_cur;
    if (first_byte) begin
      s0.byte_position   = '0;
      s0.field_shift     = '0;
      s0.bytes_remaining = '0;
      s0.stored_length   = '0;
      s0.error_latched   = ERR_NONE;
      s0.parse_phase     = PH_HEADER;
    end
  end

  always_comb begin
    priority if (tag.hit && byte_in != tag.ch) begin
      hdr_err = tag.err;
    end else if (s0.byte_position == POS_FORMAT && shifted[31:16] != PCM_FORMAT) begin
      hdr_err = ERR_NOT_PCM;
    end else if (s0.byte_position == POS_CHANNELS && shifted[31:16] != ONE_CHANNEL) begin
      hdr_err = ERR_CHANNELS;
    end else if (s0.byte_position == POS_RATE && shifted != cfg.rate_req) begin
      hdr_err = ERR_RATE;
    end else if (s0.byte_position == POS_BITS && shifted[31:16] != cfg.depth_req) begin
      hdr_err = ERR_BITS;
    end else begin
      hdr_err = ERR_NONE;
    end
  end

  // next state
  always_comb begin
    state_next = s0;
    err        = ERR_NONE;
    unique case (s0.parse_phase)
      PH_HEADER: begin
        state_next.field_shift = shifted;
        if (hdr_err != ERR_NONE) begin
          err = hdr_err;
        end else begin
          state_next.byte_position = s0.byte_position + POS_W'(1);
          if (s0.byte_position == POS_LENGTH) begin
            state_next.stored_length   = shifted;
            state_next.bytes_remaining = shifted;
            priority if (shifted == 32'd0) state_next.parse_phase = PH_STOP;
            else if (end_of_file)          err = ERR_EARLY_END;
            else                           state_next.parse_phase = PH_PAYLOAD;
          end else if (end_of_file) begin
            err = ERR_EARLY_END;
          end
        end
      end
      PH_PAYLOAD: begin
        state_next.bytes_remaining = remaining_dec;
        if (remaining_dec == 32'd0) state_next.parse_phase = PH_STOP;
        else if (end_of_file)       err = ERR_EARLY_END;
      end
      PH_IDLE, PH_STOP: begin
      end
    endcase
    if (err != ERR_NONE) begin
      state_next.error_latched = err;
      state_next.parse_phase   = PH_STOP;
    end
  end

  // outputs
  always_comb begin
    result.sample_valid = (s0.parse_phase == PH_PAYLOAD);
    result.sample_byte  = result.sample_valid ? byte_in : 8'h00;
    result.last_sample  = result.sample_valid && (remaining_dec == 32'd0);
    result.header_done  = (state_next.byte_position == POS_DONE);
    result.error_code   = state_next.error_latched;
    result.data_length  = state_next.stored_length;
  end

endmodule

@@ rtl/wav_pcm_header_parser.sv @@
// Byte-stream WAV header checker: one file byte per transfer, one result per byte. An
// input register and a result register surround the parse logic, so a byte can be taken
// every cycle unless the result register is stalled; a byte waits in the input register
// until the result register is free to take its result. The rate is set by the single
// state update per byte. first_byte restarts parsing, the 44-byte header is checked for
// its tags, PCM format and one channel and against the configured sample rate and bit
// depth, payload bytes that follow pass through with last_sample on the final one, and
// error_code latches the first failure and holds until the next file start. The user
// must write configuration while no byte is in flight; the block does not enforce it.
module wav_pcm_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        first_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        sample_valid,
  output logic [7:0]  sample_byte,
  output logic        last_sample,
  output logic        header_done,
  output logic [3:0]  error_code,
  output logic [31:0] data_length
);
  import wpp_pkg::*;

  cfg_t       cfg;
  state_t     state;
  state_t     state_next;
  result_t    result_next;
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_first;
  logic       in_eof;
  logic       accept;
  logic       advance;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_req  <= RESET_RATE;
      cfg.depth_req <= RESET_DEPTH;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SAMPLE_RATE: cfg.rate_req  <= cfg_data;
        CFG_BIT_DEPTH:   cfg.depth_req <= cfg_data[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= accept || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte  <= byte_in;
      in_first <= first_byte;
      in_eof   <= end_of_file;
    end
  end

  wpp_step u_step (
    .state_cur   (state),
    .cfg         (cfg),
    .byte_in     (in_byte),
    .first_byte  (in_first),
    .end_of_file (in_eof),
    .state_next  (state_next),
    .result      (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.byte_position   <= '0;
      state.field_shift     <= '0;
      state.bytes_remaining <= '0;
      state.stored_length   <= '0;
      state.parse_phase     <= PH_IDLE;
      state.error_latched   <= ERR_NONE;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_valid <= result_next.sample_valid;
      sample_byte  <= result_next.sample_byte;
      last_sample  <= result_next.last_sample;
      header_done  <= result_next.header_done;
      error_code   <= result_next.error_code;
      data_length  <= result_next.data_length;
    end
  end

  a_err_stops: assert property (@(posedge clk) disable iff (rst)
    state.error_latched != ERR_NONE |-> state.parse_phase == PH_STOP)
    else $error("latched error while parser still running");

  a_payload_after_header: assert property (@(posedge clk) disable iff (rst)
    state.parse_phase == PH_PAYLOAD |-> state.byte_position == POS_DONE)
    else $error("payload phase before header complete");

  a_last_is_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_sample |-> sample_valid && header_done)
    else $error("last_sample without a payload byte");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register lost a transfer");

  a_no_accept_when_busy: assert property (@(posedge clk) disable iff (rst)
    in_full && out_valid && out_stall |-> in_stall)
    else $error("input register overwritten while blocked");

endmodule
